// ===== rtl/core/blpwm_pkg.sv =====
`default_nettype none

package blpwm_pkg;

    localparam int STEPS   = 100;
    localparam int STEP_W  = $clog2(STEPS + 1);
    localparam int FRAC_W  = 17;
    localparam int PERIOD_W = 16;
    localparam int COUNT_W = 8;

    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 16'd5000;
    localparam logic [COUNT_W-1:0]  PPS_RST        = 8'd5;
    localparam logic [COUNT_W-1:0]  MIN_PULSE_RST  = 8'd2;

    localparam logic [7:0] CMD_OFF     = 8'h30;
    localparam logic [7:0] CMD_ON      = 8'h31;
    localparam logic [7:0] CMD_BREATHE = 8'h32;

    typedef enum logic [1:0] {
        CFG_PWM_PERIOD = 2'd0,
        CFG_PERIODS_PER_STEP = 2'd1,
        CFG_MIN_PULSE = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_OFF = 2'd0,
        MODE_ON = 2'd1,
        MODE_BREATHE = 2'd2
    } mode_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_BYTE = 1'b1
    } kind_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       led;
        logic [1:0] mode;
        logic [6:0] step_index;
    } out_item_t;

    typedef logic [FRAC_W-1:0] frac_rom_t [0:STEPS];
    typedef logic [16:0] sine_rom_t [0:32];

    localparam sine_rom_t SINE_Q16 = '{
        17'd0,     17'd3216,  17'd6424,  17'd9616,  17'd12785, 17'd15924,
        17'd19024, 17'd22078, 17'd25080, 17'd28020, 17'd30893, 17'd33692,
        17'd36410, 17'd39040, 17'd41576, 17'd44011, 17'd46341, 17'd48559,
        17'd50660, 17'd52639, 17'd54491, 17'd56212, 17'd57798, 17'd59244,
        17'd60547, 17'd61705, 17'd62714, 17'd63572, 17'd64277, 17'd64827,
        17'd65220, 17'd65457, 17'd65536
    };

    // raised-sine brightness per step, Q16, built at elaboration
    function automatic frac_rom_t build_frac_rom();
        frac_rom_t   rom;
        logic [63:0] pos;
        logic [63:0] k;
        logic [63:0] f;
        logic [63:0] s;
        logic [63:0] sq;
        for (int i = 0; i <= STEPS; i++) begin
            pos = 64'(i) * 64'd32768 / 64'(STEPS);
            k   = (pos >> 10) & 64'd63;
            f   = pos & 64'd1023;
            if (k >= 64'd32) begin
                s = 64'(SINE_Q16[32]);
            end else begin
                s = 64'(SINE_Q16[k[5:0]]) +
                    (((64'(SINE_Q16[k[5:0] + 6'd1]) - 64'(SINE_Q16[k[5:0]])) * f) >> 10);
            end
            sq = (s * s + 64'd32768) >> 16;
            rom[i] = sq[FRAC_W-1:0];
        end
        return rom;
    endfunction

    localparam frac_rom_t FRAC_ROM = build_frac_rom();

endpackage

`default_nettype wire

// ===== rtl/core/breathing_led_pwm_controller.sv =====
`default_nettype none

// Breathing LED PWM controller. Each input transfer is either a one microsecond
// tick or a received command byte ('1' steady on, '0' off, '2' breathing), and
// each yields one result transfer with the LED level, mode and sweep step after
// it. One transfer is taken per clock cycle while not stalled, with the result
// registered; the rate is set by the state update path, where the next step
// selects a duty value from the raised-sine table and one 17x16 multiply by the
// period registers the on time for the following tick. Configuration is written
// through cfg_we / cfg_addr / cfg_wdata while no transfer is outstanding.
module breathing_led_pwm_controller
    import blpwm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire in_item_t            s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output out_item_t                m_data,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_addr,
    input  wire logic [PERIOD_W-1:0] cfg_wdata
);

    logic [PERIOD_W-1:0] pwm_period_reg, pwm_period_next;
    logic [COUNT_W-1:0]  pps_reg, pps_next;
    logic [COUNT_W-1:0]  min_pulse_reg, min_pulse_next;

    mode_t               mode_reg, mode_next;
    logic                led_reg, led_next;
    logic [STEP_W-1:0]   step_pos_reg, step_pos_next;
    logic                falling_reg, falling_next;
    logic [COUNT_W-1:0]  repeat_reg, repeat_next;
    logic [PERIOD_W-1:0] tick_reg, tick_next;
    logic [PERIOD_W-1:0] on_time_reg, on_time_next;
    logic                m_valid_reg, m_valid_next;

    logic                     accept;
    logic [PERIOD_W-1:0]      off_time;
    logic                     on_ok;
    logic                     off_ok;
    logic                     wrap;
    logic                     step_adv;
    logic [FRAC_W-1:0]        frac_next;
    logic [FRAC_W+PERIOD_W-1:0] product;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    assign m_data.led        = led_reg;
    assign m_data.mode       = mode_reg;
    assign m_data.step_index = 7'(step_pos_reg);

    always_comb begin
        pwm_period_next = pwm_period_reg;
        pps_next        = pps_reg;
        min_pulse_next  = min_pulse_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_PWM_PERIOD:       pwm_period_next = cfg_wdata;
                CFG_PERIODS_PER_STEP: pps_next        = cfg_wdata[COUNT_W-1:0];
                CFG_MIN_PULSE:        min_pulse_next  = cfg_wdata[COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    assign off_time = pwm_period_reg - on_time_reg;
    assign on_ok    = on_time_reg > {8'd0, min_pulse_reg};
    assign off_ok   = off_time > {8'd0, min_pulse_reg};
    assign wrap     = ({1'b0, tick_reg} + 17'd1) >= {1'b0, pwm_period_reg};
    assign step_adv = wrap && (({1'b0, repeat_reg} + 9'd1) >= {1'b0, pps_reg});

    always_comb begin
        mode_next     = mode_reg;
        led_next      = led_reg;
        step_pos_next = step_pos_reg;
        falling_next  = falling_reg;
        repeat_next   = repeat_reg;
        tick_next     = tick_reg;
        if (accept) begin
            if (s_data.kind == KIND_TICK) begin
                if (mode_reg == MODE_BREATHE) begin
                    if (on_ok || off_ok) begin
                        led_next = (tick_reg < on_time_reg) ? on_ok : !off_ok;
                    end
                    if (wrap) begin
                        tick_next = '0;
                        if (step_adv) begin
                            repeat_next = '0;
                            if (!falling_reg) begin
                                if (step_pos_reg < STEP_W'(STEPS)) begin
                                    step_pos_next = step_pos_reg + 1'b1;
                                end else begin
                                    falling_next = 1'b1;
                                end
                            end else begin
                                if (step_pos_reg != '0) begin
                                    step_pos_next = step_pos_reg - 1'b1;
                                end else begin
                                    falling_next = 1'b0;
                                end
                            end
                        end else begin
                            repeat_next = repeat_reg + 1'b1;
                        end
                    end else begin
                        tick_next = tick_reg + 1'b1;
                    end
                end
            end else begin
                if (mode_reg == MODE_BREATHE || s_data.rx_byte == CMD_BREATHE) begin
                    step_pos_next = '0;
                    falling_next  = 1'b0;
                    repeat_next   = '0;
                    tick_next     = '0;
                end
                case (s_data.rx_byte)
                    CMD_ON: begin
                        mode_next = MODE_ON;
                        led_next  = 1'b1;
                    end
                    CMD_OFF: begin
                        mode_next = MODE_OFF;
                        led_next  = 1'b0;
                    end
                    CMD_BREATHE: mode_next = MODE_BREATHE;
                    default: ;
                endcase
            end
        end
    end

    // on time for the step and period that hold at the next edge
    assign frac_next    = FRAC_ROM[step_pos_next];
    assign product      = frac_next * pwm_period_next;
    assign on_time_next = product[PERIOD_W+15:16];

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_period_reg <= PWM_PERIOD_RST;
            pps_reg        <= PPS_RST;
            min_pulse_reg  <= MIN_PULSE_RST;
            mode_reg       <= MODE_OFF;
            led_reg        <= 1'b0;
            step_pos_reg   <= '0;
            falling_reg    <= 1'b0;
            repeat_reg     <= '0;
            tick_reg       <= '0;
            on_time_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pwm_period_reg <= pwm_period_next;
            pps_reg        <= pps_next;
            min_pulse_reg  <= min_pulse_next;
            mode_reg       <= mode_next;
            led_reg        <= led_next;
            step_pos_reg   <= step_pos_next;
            falling_reg    <= falling_next;
            repeat_reg     <= repeat_next;
            tick_reg       <= tick_next;
            on_time_reg    <= on_time_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_pos_reg <= STEP_W'(STEPS))
        else $error("step index beyond sweep end");

    a_on_time_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        on_time_reg <= pwm_period_reg)
        else $error("on time exceeds period");

    a_off_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.kind == KIND_BYTE && s_data.rx_byte == CMD_OFF
        |=> mode_reg == MODE_OFF && !led_reg)
        else $error("off command not applied");

    a_idle_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.kind == KIND_TICK && mode_reg != MODE_BREATHE
        |=> $stable(step_pos_reg) && $stable(led_reg) && $stable(tick_reg))
        else $error("tick changed state outside breathing");

    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(step_pos_reg) && $stable(mode_reg))
        else $error("state moved while result stalled");

endmodule

`default_nettype wire
